>>> rtl/core/bilrgb_pkg.sv
package bilrgb_pkg;

  // image limits and derived widths
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int WdimW      = ColW + 1;
  localparam int HdimW      = RowW + 1;
  localparam int StoreDepth = MaxWidth * MaxHeight;
  localparam int AddrW      = $clog2(StoreDepth);

  // fixed field widths
  localparam int DimW    = 9;
  localparam int IndexW  = 16;
  localparam int ChanW   = 8;
  localparam int FracW   = 16;
  localparam int CoordW  = FracW + 1;
  localparam int AccW    = ChanW + FracW;
  localparam int MixW    = ChanW + 2 * FracW;
  localparam logic [CoordW-1:0] OneQ16 = CoordW'(1 << FracW);

  typedef enum logic {
    ActWrite  = 1'b0,
    ActSample = 1'b1
  } action_e;

  typedef enum logic {
    CfgWidth  = 1'b0,
    CfgHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    NbTopLeft  = 2'd0,
    NbTopRight = 2'd1,
    NbBotLeft  = 2'd2,
    NbBotRight = 2'd3
  } nb_e;

  typedef enum logic [3:0] {
    StIdle,
    StScale,
    StAddr,
    StRd0,
    StRd1,
    StRd2,
    StRd3,
    StRd4,
    StMix
  } state_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [AccW-1:0] red;
    logic [AccW-1:0] green;
    logic [AccW-1:0] blue;
  } result_t;

  // control towards the address generator
  typedef struct packed {
    logic load;
    logic scale;
    logic index;
    nb_e  nb;
  } addr_ctl_t;

  // control towards the blend datapath
  typedef struct packed {
    logic top_ld;
    logic top_acc;
    logic bot_ld;
    logic bot_acc;
    logic mix_ld;
  } blend_ctl_t;

endpackage

>>> rtl/core/bilrgb_pix_mem.sv
module bilrgb_pix_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bilrgb_pkg::AddrW-1:0]  addr_i,
  input  bilrgb_pkg::pixel_t            wdata_i,
  output bilrgb_pkg::pixel_t            rdata_o
);

  bilrgb_pkg::pixel_t mem_q [bilrgb_pkg::StoreDepth];
  bilrgb_pkg::pixel_t rdata_q;

  // single port: a write or a registered read each cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bilrgb_addr_gen.sv
module bilrgb_addr_gen (
  input  logic                           clk_i,
  input  bilrgb_pkg::addr_ctl_t          ctl_i,
  input  logic [bilrgb_pkg::DimW-1:0]    cfg_width_i,
  input  logic [bilrgb_pkg::DimW-1:0]    cfg_height_i,
  input  logic [bilrgb_pkg::CoordW-1:0]  coord_u_i,
  input  logic [bilrgb_pkg::CoordW-1:0]  coord_v_i,
  output logic [bilrgb_pkg::AddrW-1:0]   rd_addr_o,
  output logic [bilrgb_pkg::FracW-1:0]   rx_o,
  output logic [bilrgb_pkg::FracW-1:0]   ry_o
);

  localparam int XW = bilrgb_pkg::CoordW + bilrgb_pkg::ColW;
  localparam int YW = bilrgb_pkg::CoordW + bilrgb_pkg::RowW;
  localparam int PW = bilrgb_pkg::RowW + bilrgb_pkg::WdimW;

  function automatic logic [bilrgb_pkg::WdimW-1:0] clamp_w(
    input logic [bilrgb_pkg::DimW-1:0] d
  );
    logic [bilrgb_pkg::WdimW-1:0] r;
    if (d == '0) r = bilrgb_pkg::WdimW'(1);
    else if (32'(d) > bilrgb_pkg::MaxWidth) r = bilrgb_pkg::WdimW'(bilrgb_pkg::MaxWidth);
    else r = bilrgb_pkg::WdimW'(d);
    return r;
  endfunction

  function automatic logic [bilrgb_pkg::HdimW-1:0] clamp_h(
    input logic [bilrgb_pkg::DimW-1:0] d
  );
    logic [bilrgb_pkg::HdimW-1:0] r;
    if (d == '0) r = bilrgb_pkg::HdimW'(1);
    else if (32'(d) > bilrgb_pkg::MaxHeight) r = bilrgb_pkg::HdimW'(bilrgb_pkg::MaxHeight);
    else r = bilrgb_pkg::HdimW'(d);
    return r;
  endfunction

  logic [bilrgb_pkg::CoordW-1:0] u_q, vf_q;
  logic [bilrgb_pkg::CoordW-1:0] u_sat, v_sat;
  logic [bilrgb_pkg::WdimW-1:0]  w_d, w_q;
  logic [bilrgb_pkg::HdimW-1:0]  h_d;
  logic [bilrgb_pkg::ColW-1:0]   wm1_q;
  logic [bilrgb_pkg::RowW-1:0]   hm1_q;
  logic [XW-1:0]                 x_d, x_q;
  logic [YW-1:0]                 y_d, y_q;
  logic [bilrgb_pkg::ColW-1:0]   ix0, ix1, col0_q, col1_q, col_sel;
  logic [bilrgb_pkg::RowW-1:0]   iy0, iy1;
  logic [PW-1:0]                 prod0, prod1;
  logic [bilrgb_pkg::AddrW-1:0]  row0_q, row1_q, row_sel;
  logic [bilrgb_pkg::FracW-1:0]  rx_q, ry_q;

  // saturate coordinates and clamp the dimensions; v is flipped when loaded
  always_comb begin
    u_sat = (coord_u_i > bilrgb_pkg::OneQ16) ? bilrgb_pkg::OneQ16 : coord_u_i;
    v_sat = (coord_v_i > bilrgb_pkg::OneQ16) ? bilrgb_pkg::OneQ16 : coord_v_i;
    w_d   = clamp_w(cfg_width_i);
    h_d   = clamp_h(cfg_height_i);
  end

  // scale into pixel space
  assign x_d = XW'(u_q) * XW'(wm1_q);
  assign y_d = YW'(vf_q) * YW'(hm1_q);

  // integer parts, clamped right and lower neighbours, row bases
  always_comb begin
    ix0   = x_q[bilrgb_pkg::FracW +: bilrgb_pkg::ColW];
    iy0   = y_q[bilrgb_pkg::FracW +: bilrgb_pkg::RowW];
    ix1   = (ix0 == wm1_q) ? ix0 : ix0 + 1'b1;
    iy1   = (iy0 == hm1_q) ? iy0 : iy0 + 1'b1;
    prod0 = PW'(iy0) * PW'(w_q);
    prod1 = PW'(iy1) * PW'(w_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      u_q   <= u_sat;
      vf_q  <= bilrgb_pkg::OneQ16 - v_sat;
      w_q   <= w_d;
      wm1_q <= bilrgb_pkg::ColW'(w_d - 1'b1);
      hm1_q <= bilrgb_pkg::RowW'(h_d - 1'b1);
    end
    if (ctl_i.scale) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (ctl_i.index) begin
      col0_q <= ix0;
      col1_q <= ix1;
      row0_q <= bilrgb_pkg::AddrW'(prod0);
      row1_q <= bilrgb_pkg::AddrW'(prod1);
      rx_q   <= x_q[bilrgb_pkg::FracW-1:0];
      ry_q   <= y_q[bilrgb_pkg::FracW-1:0];
    end
  end

  // neighbour address
  always_comb begin
    unique case (ctl_i.nb)
      bilrgb_pkg::NbTopLeft: begin
        row_sel = row0_q;
        col_sel = col0_q;
      end
      bilrgb_pkg::NbTopRight: begin
        row_sel = row0_q;
        col_sel = col1_q;
      end
      bilrgb_pkg::NbBotLeft: begin
        row_sel = row1_q;
        col_sel = col0_q;
      end
      bilrgb_pkg::NbBotRight: begin
        row_sel = row1_q;
        col_sel = col1_q;
      end
      default: begin
        row_sel = row0_q;
        col_sel = col0_q;
      end
    endcase
  end

  assign rd_addr_o = row_sel + bilrgb_pkg::AddrW'(col_sel);
  assign rx_o      = rx_q;
  assign ry_o      = ry_q;

endmodule

>>> rtl/core/bilrgb_blend.sv
module bilrgb_blend (
  input  logic                          clk_i,
  input  bilrgb_pkg::blend_ctl_t        ctl_i,
  input  bilrgb_pkg::pixel_t            pixel_i,
  input  logic [bilrgb_pkg::FracW-1:0]  rx_i,
  input  logic [bilrgb_pkg::FracW-1:0]  ry_i,
  output bilrgb_pkg::result_t           result_o
);

  localparam int PW = bilrgb_pkg::CoordW + bilrgb_pkg::ChanW;
  localparam int MW = bilrgb_pkg::CoordW + bilrgb_pkg::AccW;

  logic [bilrgb_pkg::ChanW-1:0]  byte_c   [3];
  logic [bilrgb_pkg::CoordW-1:0] wx, wy_n;
  logic [PW-1:0]                 lerp_p   [3];
  logic [MW-1:0]                 mix_p    [3];
  logic [MW-1:0]                 fin_p    [3];
  logic [bilrgb_pkg::MixW-1:0]   fin_s    [3];
  logic [bilrgb_pkg::AccW-1:0]   res_c    [3];
  logic [bilrgb_pkg::AccW-1:0]   top_q    [3];
  logic [bilrgb_pkg::AccW-1:0]   bot_q    [3];
  logic [bilrgb_pkg::MixW-1:0]   mix_q    [3];

  assign byte_c[0] = pixel_i.red;
  assign byte_c[1] = pixel_i.green;
  assign byte_c[2] = pixel_i.blue;

  // left neighbour takes 1-rx, right neighbour rx
  assign wx   = (ctl_i.top_ld || ctl_i.bot_ld) ?
                (bilrgb_pkg::OneQ16 - bilrgb_pkg::CoordW'(rx_i)) : bilrgb_pkg::CoordW'(rx_i);
  assign wy_n = bilrgb_pkg::OneQ16 - bilrgb_pkg::CoordW'(ry_i);

  // one multiplier per channel lane and step
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lerp_p[c] = PW'(wx) * PW'(byte_c[c]);
      mix_p[c]  = MW'(wy_n) * MW'(top_q[c]);
      fin_p[c]  = MW'(ry_i) * MW'(bot_q[c]);
      fin_s[c]  = mix_q[c] + bilrgb_pkg::MixW'(fin_p[c]);
      res_c[c]  = fin_s[c][bilrgb_pkg::FracW +: bilrgb_pkg::AccW];
    end
  end

  // horizontal lerp of upper and lower rows, then first vertical term
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (ctl_i.top_ld) begin
        top_q[c] <= bilrgb_pkg::AccW'(lerp_p[c]);
      end else if (ctl_i.top_acc) begin
        top_q[c] <= top_q[c] + bilrgb_pkg::AccW'(lerp_p[c]);
      end
      if (ctl_i.bot_ld) begin
        bot_q[c] <= bilrgb_pkg::AccW'(lerp_p[c]);
      end else if (ctl_i.bot_acc) begin
        bot_q[c] <= bot_q[c] + bilrgb_pkg::AccW'(lerp_p[c]);
      end
      if (ctl_i.mix_ld) begin
        mix_q[c] <= bilrgb_pkg::MixW'(mix_p[c]);
      end
    end
  end

  assign result_o.red   = res_c[0];
  assign result_o.green = res_c[1];
  assign result_o.blue  = res_c[2];

endmodule

>>> rtl/core/bilinear_rgb_sampler.sv
// Bilinear RGB sampler.
// Input channel (in_valid_i/in_ready_o): an item either writes one RGB8
// pixel at pixel_index_i (action_i low) or samples the image at coord_u_i,
// coord_v_i in Q1.16 (action_i high). Writes give no result.
// Output channel (out_valid_o/out_ready_i): one item per sample, three
// channels in Q8.16, equal to the interpolated intensity times 255.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 sets the image
// width, index 1 the height; always ready, write only while idle.
// Timing: a write leaves the block ready. A sample runs through the scaling
// and row address steps, the four neighbour reads through the single-port
// pixel memory (one per cycle, registered read) and the blend steps; the
// block is ready again in the same cycle that out_valid_o rises.
// A result waits in the output register; while it is not taken the block
// still accepts items, and a further sample stalls at its final blend step
// until the output register frees up.
// Reset sets width and height to 256 and empties the output register; the
// pixel memory is not cleared, so only pixels written since may be sampled.
module bilinear_rgb_sampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [bilrgb_pkg::IndexW-1:0]  pixel_index_i,
  input  logic [bilrgb_pkg::ChanW-1:0]   red_in_i,
  input  logic [bilrgb_pkg::ChanW-1:0]   green_in_i,
  input  logic [bilrgb_pkg::ChanW-1:0]   blue_in_i,
  input  logic [bilrgb_pkg::CoordW-1:0]  coord_u_i,
  input  logic [bilrgb_pkg::CoordW-1:0]  coord_v_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bilrgb_pkg::AccW-1:0]    red_out_o,
  output logic [bilrgb_pkg::AccW-1:0]    green_out_o,
  output logic [bilrgb_pkg::AccW-1:0]    blue_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [bilrgb_pkg::DimW-1:0]    cfg_data_i
);

  bilrgb_pkg::state_e             state_q, state_d;
  bilrgb_pkg::addr_ctl_t          addr_ctl;
  bilrgb_pkg::blend_ctl_t         blend_ctl;
  bilrgb_pkg::pixel_t             wr_pixel, rd_pixel;
  bilrgb_pkg::result_t            result, result_q;
  logic [bilrgb_pkg::DimW-1:0]    width_q, height_q;
  logic [bilrgb_pkg::AddrW-1:0]   rd_addr, mem_addr;
  logic [bilrgb_pkg::FracW-1:0]   rx, ry;
  logic                           in_fire, sample_fire, mem_we;
  logic                           out_free, out_load;
  logic                           out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == bilrgb_pkg::StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign sample_fire = in_fire && (action_i == bilrgb_pkg::ActSample);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bilrgb_pkg::DimW'(256);
      height_q <= bilrgb_pkg::DimW'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bilrgb_pkg::CfgWidth:  width_q  <= cfg_data_i;
        bilrgb_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pixel writes go straight to memory; out-of-range addresses are dropped
  assign mem_we   = in_fire && (action_i == bilrgb_pkg::ActWrite) &&
                    (32'(pixel_index_i) < bilrgb_pkg::StoreDepth);
  assign mem_addr = mem_we ? bilrgb_pkg::AddrW'(pixel_index_i) : rd_addr;
  assign wr_pixel = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  bilrgb_pix_mem u_pix_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wr_pixel),
    .rdata_o (rd_pixel)
  );

  bilrgb_addr_gen u_addr_gen (
    .clk_i        (clk_i),
    .ctl_i        (addr_ctl),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .coord_u_i    (coord_u_i),
    .coord_v_i    (coord_v_i),
    .rd_addr_o    (rd_addr),
    .rx_o         (rx),
    .ry_o         (ry)
  );

  bilrgb_blend u_blend (
    .clk_i    (clk_i),
    .ctl_i    (blend_ctl),
    .pixel_i  (rd_pixel),
    .rx_i     (rx),
    .ry_i     (ry),
    .result_o (result)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bilrgb_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and step controls
  always_comb begin
    state_d        = state_q;
    addr_ctl       = '0;
    addr_ctl.load  = sample_fire;
    addr_ctl.nb    = bilrgb_pkg::NbTopLeft;
    blend_ctl      = '0;
    out_load       = 1'b0;
    unique case (state_q)
      bilrgb_pkg::StIdle: begin
        if (sample_fire) state_d = bilrgb_pkg::StScale;
      end
      bilrgb_pkg::StScale: begin
        addr_ctl.scale = 1'b1;
        state_d        = bilrgb_pkg::StAddr;
      end
      bilrgb_pkg::StAddr: begin
        addr_ctl.index = 1'b1;
        state_d        = bilrgb_pkg::StRd0;
      end
      bilrgb_pkg::StRd0: begin
        addr_ctl.nb = bilrgb_pkg::NbTopLeft;
        state_d     = bilrgb_pkg::StRd1;
      end
      bilrgb_pkg::StRd1: begin
        addr_ctl.nb      = bilrgb_pkg::NbTopRight;
        blend_ctl.top_ld = 1'b1;
        state_d          = bilrgb_pkg::StRd2;
      end
      bilrgb_pkg::StRd2: begin
        addr_ctl.nb       = bilrgb_pkg::NbBotLeft;
        blend_ctl.top_acc = 1'b1;
        state_d           = bilrgb_pkg::StRd3;
      end
      bilrgb_pkg::StRd3: begin
        addr_ctl.nb      = bilrgb_pkg::NbBotRight;
        blend_ctl.bot_ld = 1'b1;
        blend_ctl.mix_ld = 1'b1;
        state_d          = bilrgb_pkg::StRd4;
      end
      bilrgb_pkg::StRd4: begin
        blend_ctl.bot_acc = 1'b1;
        state_d           = bilrgb_pkg::StMix;
      end
      bilrgb_pkg::StMix: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = bilrgb_pkg::StIdle;
        end
      end
      default: state_d = bilrgb_pkg::StIdle;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) result_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = result_q.red;
  assign green_out_o = result_q.green;
  assign blue_out_o  = result_q.blue;

endmodule
